// ===== hw/rtl/i2cblm_pkg.sv =====
`timescale 1ns / 1ps

package i2cblm_pkg;

   // Phase lengths in microsecond ticks
   localparam int unsigned TICK_W = 3;
   localparam logic [TICK_W-1:0] HIGH_DELAY_TICKS = 3'd2;
   localparam logic [TICK_W-1:0] FULL_DELAY_TICKS = 3'd5;

   localparam int unsigned BIT_W = 4;
   localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

   // Request actions
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_BEGIN  = 2'd1;
   localparam logic [1:0] ACT_SUPPLY = 2'd2;

   // Register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_SPEED_HIGH = 1'b0;

   typedef enum logic [3:0] {
      PH_IDLE, PH_S0, PH_S1, PH_S2, PH_WL, PH_WH, PH_AL, PH_AH, PH_WAIT,
      PH_RL, PH_RH, PH_ML, PH_MH, PH_P0, PH_P1
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       last_byte;
      logic [7:0] read_count;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_enable;
      logic       sda_level;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       rx_last;
      logic       want_byte;
      logic       busy_res;
      logic       done_res;
      logic       nack_error;
   } rsp_type;

endpackage

// ===== hw/rtl/i2c_bit_level_master.sv =====
`timescale 1ns / 1ps

// I2C master bit sequencer, stepped by request transfers.
// Request channel (req_valid / req_stall / req_data): each transfer is a
// one-microsecond tick carrying the sampled SDA level, a begin with the first
// write byte and the read count, or the next write byte while want_byte is set.
// Every request transfer yields exactly one response transfer on the rsp_
// channel, carrying the pin drive after that step, a completed read byte,
// and the busy, done and NACK status.
// The response is registered at the edge that accepts the request. One request
// is taken every cycle while req_stall is low; the phase machine update is a
// single step of next-state logic between the state and response registers.
// When the response receiver stalls, the response register holds and
// req_stall rises, so no request is taken until the held response leaves.
// Phase length (2 or 5 ticks) comes from the speed_high register at CSR
// byte address 0; write it only while the bus is idle.
// Reset (synchronous) returns the machine to idle with SCL high and SDA driven
// high, clears speed_high and empties the response register.
module i2c_bit_level_master
   import i2cblm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic             speed_high_ff;
   phase_type        phase_ff, phase_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [BIT_W-1:0] bit_index_ff, bit_index_in;
   logic [7:0]       shift_reg_ff, shift_reg_in;
   logic [7:0]       reads_left_ff, reads_left_in;
   logic             final_write_ff, final_write_in;
   logic             error_flag_ff, error_flag_in;
   logic             byte_pending_ff, byte_pending_in;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_take;
   logic             csr_write;
   logic [TICK_W-1:0] delay;
   logic             rx_event;
   logic [7:0]       rx_byte_event;
   logic             rx_last_event;
   logic             done_event;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SPEED_HIGH) ? {31'd0, speed_high_ff} : 32'd0;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign delay = speed_high_ff ? HIGH_DELAY_TICKS : FULL_DELAY_TICKS;

   // Next state of the phase machine for one request
   always_comb begin
      logic [TICK_W-1:0] tick_inc;
      logic [BIT_W-1:0]  bit_inc;
      logic [7:0]        reads_dec;
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      bit_index_in    = bit_index_ff;
      shift_reg_in    = shift_reg_ff;
      reads_left_in   = reads_left_ff;
      final_write_in  = final_write_ff;
      error_flag_in   = error_flag_ff;
      byte_pending_in = byte_pending_ff;
      rx_event        = 1'b0;
      rx_byte_event   = 8'd0;
      rx_last_event   = 1'b0;
      done_event      = 1'b0;
      tick_inc        = tick_count_ff + 1'b1;
      bit_inc         = bit_index_ff + 1'b1;
      reads_dec       = (reads_left_ff != 8'd0) ? reads_left_ff - 8'd1 : 8'd0;
      unique case (req_data.action)
         ACT_BEGIN: begin
            if (phase_ff == PH_IDLE) begin
               shift_reg_in    = req_data.data_byte;
               final_write_in  = req_data.last_byte;
               reads_left_in   = req_data.read_count;
               error_flag_in   = 1'b0;
               byte_pending_in = 1'b0;
               bit_index_in    = '0;
               phase_in        = PH_S0;
               tick_count_in   = '0;
            end
         end
         ACT_SUPPLY: begin
            if (phase_ff == PH_WAIT) begin
               shift_reg_in    = req_data.data_byte;
               final_write_in  = req_data.last_byte;
               byte_pending_in = 1'b0;
               bit_index_in    = '0;
               phase_in        = PH_WL;
               tick_count_in   = '0;
            end
         end
         ACT_TICK: begin
            if (phase_ff != PH_IDLE && phase_ff != PH_WAIT) begin
               if (phase_ff == PH_AH && tick_count_ff == '0 && req_data.sda_sample) begin
                  // NACK: drop SCL at once and head for STOP
                  error_flag_in = 1'b1;
                  phase_in      = PH_P0;
                  tick_count_in = '0;
               end else if (tick_inc < delay) begin
                  tick_count_in = tick_inc;
               end else begin
                  tick_count_in = '0;
                  unique case (phase_ff)
                     PH_S0: phase_in = PH_S1;
                     PH_S1: phase_in = PH_S2;
                     PH_S2: begin
                        bit_index_in = '0;
                        phase_in     = PH_WL;
                     end
                     PH_WL: phase_in = PH_WH;
                     PH_WH: begin
                        shift_reg_in = {shift_reg_ff[6:0], 1'b0};
                        bit_index_in = bit_inc;
                        phase_in     = (bit_inc >= BITS_PER_BYTE) ? PH_AL : PH_WL;
                     end
                     PH_AL: phase_in = PH_AH;
                     PH_AH: begin
                        bit_index_in = '0;
                        if (!final_write_ff) begin
                           byte_pending_in = 1'b1;
                           phase_in        = PH_WAIT;
                        end else if (reads_left_ff != 8'd0) begin
                           phase_in = PH_RL;
                        end else begin
                           phase_in = PH_P0;
                        end
                     end
                     PH_RL: phase_in = PH_RH;
                     PH_RH: begin
                        shift_reg_in = {shift_reg_ff[6:0], req_data.sda_sample};
                        bit_index_in = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                           rx_event      = 1'b1;
                           rx_byte_event = {shift_reg_ff[6:0], req_data.sda_sample};
                           rx_last_event = (reads_left_ff == 8'd1);
                           phase_in      = PH_ML;
                        end else begin
                           phase_in = PH_RL;
                        end
                     end
                     PH_ML: phase_in = PH_MH;
                     PH_MH: begin
                        reads_left_in = reads_dec;
                        bit_index_in  = '0;
                        phase_in      = (reads_dec != 8'd0) ? PH_RL : PH_P0;
                     end
                     PH_P0: phase_in = PH_P1;
                     PH_P1: begin
                        done_event = 1'b1;
                        phase_in   = PH_IDLE;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         end
         default: begin
            // no operation: report the current state
         end
      endcase
   end

   // Pin drive and status after the step
   always_comb begin
      rsp_data_in = '0;
      unique case (phase_in)
         PH_S1: begin
            rsp_data_in.scl_level  = 1'b1;
            rsp_data_in.sda_enable = 1'b1;
         end
         PH_S2, PH_P0: begin
            rsp_data_in.sda_enable = 1'b1;
         end
         PH_WL: begin
            rsp_data_in.sda_enable = 1'b1;
            rsp_data_in.sda_level  = shift_reg_in[7];
         end
         PH_WH: begin
            rsp_data_in.scl_level  = 1'b1;
            rsp_data_in.sda_enable = 1'b1;
            rsp_data_in.sda_level  = shift_reg_in[7];
         end
         PH_AL, PH_WAIT, PH_RL: begin
            rsp_data_in.scl_level = 1'b0;
         end
         PH_AH, PH_RH: begin
            rsp_data_in.scl_level = 1'b1;
         end
         PH_ML: begin
            rsp_data_in.sda_enable = 1'b1;
            rsp_data_in.sda_level  = (reads_left_in == 8'd1);
         end
         PH_MH: begin
            rsp_data_in.scl_level  = 1'b1;
            rsp_data_in.sda_enable = 1'b1;
            rsp_data_in.sda_level  = (reads_left_in == 8'd1);
         end
         PH_P1: begin
            rsp_data_in.scl_level  = 1'b1;
            rsp_data_in.sda_enable = 1'b1;
         end
         default: begin
            rsp_data_in.scl_level  = 1'b1;
            rsp_data_in.sda_enable = 1'b1;
            rsp_data_in.sda_level  = 1'b1;
         end
      endcase
      rsp_data_in.rx_byte    = rx_byte_event;
      rsp_data_in.rx_valid   = rx_event;
      rsp_data_in.rx_last    = rx_last_event;
      rsp_data_in.want_byte  = byte_pending_in;
      rsp_data_in.busy_res   = (phase_in != PH_IDLE);
      rsp_data_in.done_res   = done_event;
      rsp_data_in.nack_error = error_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_high_ff   <= 1'b0;
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= '0;
         bit_index_ff    <= '0;
         shift_reg_ff    <= '0;
         reads_left_ff   <= '0;
         final_write_ff  <= 1'b0;
         error_flag_ff   <= 1'b0;
         byte_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write && csr_paddr[2] == REG_SPEED_HIGH) begin
            speed_high_ff <= csr_pwdata[0];
         end
         if (req_take) begin
            phase_ff        <= phase_in;
            tick_count_ff   <= tick_count_in;
            bit_index_ff    <= bit_index_in;
            shift_reg_ff    <= shift_reg_in;
            reads_left_ff   <= reads_left_in;
            final_write_ff  <= final_write_in;
            error_flag_ff   <= error_flag_in;
            byte_pending_ff <= byte_pending_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A write byte is requested exactly while the machine waits for one
   a_pending_wait: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT) == byte_pending_ff)
      else $error("byte_pending out of step with wait phase");

   // The tick counter never reaches the phase length
   a_tick_bound: assert property (@(posedge clock) disable iff (reset)
      tick_count_ff < delay)
      else $error("tick counter reached phase length");

   // A completed read byte arrives with SCL low and SDA driven for the ACK bit
   a_rx_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rx_valid |->
         !rsp_data_ff.scl_level && rsp_data_ff.sda_enable && !rsp_data_ff.done_res)
      else $error("read byte reported outside the ACK phase");

   // STOP completion leaves the machine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res)
      else $error("done reported while still busy");

endmodule
